[rtl/luf_pkg.sv]
`timescale 1ns / 1ps

package luf_pkg;

    localparam int unsigned LUF_CP_W       = 21;
    localparam int unsigned LUF_MAX_RES    = 3;
    localparam int unsigned LUF_FIFO_DEPTH = 4;

    typedef logic [LUF_CP_W-1:0] t_cp;
    typedef logic [7:0]          t_byte;
    typedef logic [2:0]          t_len;   // 0 invalid, 1 plain, 2..4 lead

    localparam t_cp LUF_REPL_CP = 21'h00_FFFD;

    // One queue entry: every result one input byte causes.
    typedef struct packed {
        logic [1:0]                  n;     // result count, 1..3
        logic                        done;  // byte closed the string
        t_cp [LUF_MAX_RES-1:0]       cp;    // slot 0 goes out first
    } t_rec;

    function automatic t_len seq_len(input t_byte c);
        t_len len;
        if (c[7] == 1'b0) begin
            len = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (c[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (c[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic t_cp dec2(input t_byte a, input t_byte b);
        return {10'd0, a[4:0], b[5:0]};
    endfunction

    function automatic t_cp dec3(input t_byte a, input t_byte b, input t_byte c);
        return {5'd0, a[3:0], b[5:0], c[5:0]};
    endfunction

    function automatic t_cp dec4(input t_byte a, input t_byte b, input t_byte c,
                                 input t_byte d);
        return {a[2:0], b[5:0], c[5:0], d[5:0]};
    endfunction

    // Plain byte passes through, anything else becomes the replacement.
    function automatic t_cp plain_or_repl(input t_byte c);
        t_cp cp;
        if (c[7] == 1'b0) begin
            cp = {13'd0, c};
        end else begin
            cp = LUF_REPL_CP;
        end
        return cp;
    endfunction

endpackage

[rtl/luf_front.sv]
`timescale 1ns / 1ps

module luf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  luf_pkg::t_byte     i_byte_in,
    input  logic               i_string_end,
    output logic               o_wr,
    output luf_pkg::t_rec      o_rec
);

    luf_pkg::t_byte r_pend [3];   // lead first; no reset, read only once written
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    logic           acc;
    luf_pkg::t_len  len_b;
    luf_pkg::t_len  len_l;
    luf_pkg::t_byte s1;
    luf_pkg::t_byte s2;
    luf_pkg::t_byte t0;
    logic           buf_en;
    logic [1:0]     buf_idx;
    logic [1:0]     cnt_aft;
    logic [1:0]     res_n;
    luf_pkg::t_cp   cp0;
    luf_pkg::t_cp   cp1;
    luf_pkg::t_cp   cp2;

    assign acc = i_push & ~i_full;

    always_comb begin
        len_b   = luf_pkg::seq_len(i_byte_in);
        len_l   = luf_pkg::seq_len(r_pend[0]);
        s1      = (r_cnt == 2'd1) ? i_byte_in : r_pend[1];
        s2      = (r_cnt == 2'd2) ? i_byte_in : r_pend[2];
        buf_en  = 1'b0;
        buf_idx = r_cnt;
        cnt_aft = r_cnt;
        res_n   = 2'd0;
        cp0     = luf_pkg::LUF_REPL_CP;
        cp1     = luf_pkg::LUF_REPL_CP;
        cp2     = luf_pkg::LUF_REPL_CP;

        if (r_cnt == 2'd0) begin
            if (len_b == 3'd1) begin
                res_n = 2'd1;
                cp0   = {13'd0, i_byte_in};
            end else if (len_b == 3'd0) begin
                res_n = 2'd1;
            end else begin
                buf_en  = 1'b1;
                buf_idx = 2'd0;
                cnt_aft = 2'd1;
            end
        end else if (len_l < 3'd2 || ({1'b0, r_cnt} + 3'd1) >= len_l) begin
            // sequence complete with this byte
            res_n   = 2'd1;
            cnt_aft = 2'd0;
            case (len_l)
                3'd2:    cp0 = luf_pkg::dec2(r_pend[0], s1);
                3'd3:    cp0 = luf_pkg::dec3(r_pend[0], s1, s2);
                3'd4:    cp0 = luf_pkg::dec4(r_pend[0], s1, s2, i_byte_in);
                default: cp0 = luf_pkg::LUF_REPL_CP;
            endcase
        end else begin
            buf_en  = 1'b1;
            cnt_aft = r_cnt + 2'd1;
        end

        // truncated tail: lead -> U+FFFD, then redecode the bytes after it
        t0 = (cnt_aft == 2'd2) ? i_byte_in : r_pend[1];
        if (i_string_end && cnt_aft != 2'd0) begin
            cp0 = luf_pkg::LUF_REPL_CP;
            case (cnt_aft)
                2'd1: begin
                    res_n = 2'd1;
                end
                2'd2: begin
                    res_n = 2'd2;
                    cp1   = luf_pkg::plain_or_repl(t0);
                end
                2'd3: begin
                    if (t0[7] == 1'b0) begin
                        res_n = 2'd3;
                        cp1   = {13'd0, t0};
                        cp2   = luf_pkg::plain_or_repl(i_byte_in);
                    end else if (luf_pkg::seq_len(t0) == 3'd2) begin
                        res_n = 2'd2;
                        cp1   = luf_pkg::dec2(t0, i_byte_in);
                    end else begin
                        res_n = 2'd3;
                        cp2   = luf_pkg::plain_or_repl(i_byte_in);
                    end
                end
                default: begin
                    res_n = 2'd1;
                end
            endcase
        end

        n_cnt = i_string_end ? 2'd0 : cnt_aft;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (acc) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && buf_en) begin
            r_pend[buf_idx] <= i_byte_in;
        end
    end

    assign o_wr        = acc && (res_n != 2'd0);
    assign o_rec.n     = res_n;
    assign o_rec.done  = i_string_end;
    assign o_rec.cp[0] = cp0;
    assign o_rec.cp[1] = cp1;
    assign o_rec.cp[2] = cp2;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_string_end |=> r_cnt == 2'd0)
        else $error("string end left bytes buffered");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_string_end |-> o_wr)
        else $error("string end produced no result");

endmodule

[rtl/luf_fifo.sv]
`timescale 1ns / 1ps

module luf_fifo #(
    parameter int unsigned DEPTH = luf_pkg::LUF_FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  luf_pkg::t_rec  i_rec,
    input  logic           i_rd,
    output luf_pkg::t_rec  o_head,
    output logic           o_full,
    output logic           o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    luf_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          wr_ok;
    logic          rd_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr & ~o_full;
    assign rd_ok   = i_rd & ~o_empty;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_ONE;
            end
            if (rd_ok) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_ONE;
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + CNT_ONE;
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - CNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

    a_wr_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("record written into full queue");

endmodule

[rtl/luf_back.sv]
`timescale 1ns / 1ps

module luf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  luf_pkg::t_rec      i_head,
    input  logic               i_empty,
    input  logic               i_pop,
    output logic               o_rd,
    output luf_pkg::t_cp       o_code_point,
    output logic               o_last_of_run,
    output logic               o_string_done
);

    logic [1:0] r_idx;   // slot of the head record now on the ports
    logic       last;
    logic       take;

    assign take = i_pop & ~i_empty;
    assign last = (r_idx == (i_head.n - 2'd1));

    always_comb begin
        case (r_idx)
            2'd0:    o_code_point = i_head.cp[0];
            2'd1:    o_code_point = i_head.cp[1];
            2'd2:    o_code_point = i_head.cp[2];
            default: o_code_point = luf_pkg::LUF_REPL_CP;
        endcase
    end

    assign o_last_of_run = last;
    assign o_string_done = last & i_head.done;
    assign o_rd          = take & last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

    a_idx_in_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> r_idx < i_head.n)
        else $error("slot index beyond record");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> r_idx == 2'd0)
        else $error("slot index left over with queue empty");

endmodule

[rtl/lenient_utf8_decoder.sv]
// Output: a byte with results is queued at the edge that accepts it; if the queue was
//   empty, its first code point shows (empty low) right after that edge; the rest follow per pop.
// Throughput: one byte per cycle unless full; a byte that causes m results holds the
//   result side for m pops (m is 3 at most, only on a truncated string tail).
// Reset: synchronous, active low; clears the buffered count and the queue pointers.
`timescale 1ns / 1ps

module lenient_utf8_decoder #(
    parameter int unsigned FIFO_DEPTH = luf_pkg::LUF_FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte side
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_byte_in,
    input  logic                  i_string_end,
    // code point side
    output logic                  empty,
    input  logic                  pop,
    output logic [20:0]           o_code_point,
    output logic                  o_last_of_run,
    output logic                  o_string_done
);

    // Front: holds the partial sequence (up to three bytes) and turns each byte
    // into one record carrying every code point it causes, tail redecode included.
    // Bytes that only extend a sequence make no record.
    luf_pkg::t_rec rec_in;
    luf_pkg::t_rec rec_head;
    logic          rec_wr;
    logic          rec_rd;
    logic          q_empty;

    luf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_byte_in    (i_byte_in),
        .i_string_end (i_string_end),
        .o_wr         (rec_wr),
        .o_rec        (rec_in)
    );

    // Record queue: lets the byte side keep going while results wait to be taken.
    luf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rec_wr),
        .i_rec   (rec_in),
        .i_rd    (rec_rd),
        .o_head  (rec_head),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // Back: walks the slots of the head record, one item per pop.
    luf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (rec_head),
        .i_empty       (q_empty),
        .i_pop         (pop),
        .o_rd          (rec_rd),
        .o_code_point  (o_code_point),
        .o_last_of_run (o_last_of_run),
        .o_string_done (o_string_done)
    );

    assign empty = q_empty;

endmodule
